// ===== sv/brf_pkg.sv =====
package brf_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CAP_W  = 9;
    localparam int ST_W   = 2;

    localparam int DEPTH_DEF     = 256;
    localparam int MAX_BURST_DEF = 64;

    // op codes on the input channel
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OP_W-1:0] OP_READ      = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_MANY = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_LINE = 3'd4;
    localparam logic [OP_W-1:0] OP_FLUSH     = 3'd5;

    // status codes on the output channel
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_NOLINE = 2'd3;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        K_WRITE,
        K_BURST,
        K_LINE,
        K_FLUSH
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              pop;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  lim;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              has_byte;
        logic [ST_W-1:0]   status;
        logic              last;
    } t_beat;

endpackage

// ===== sv/brf_front.sv =====
module brf_front #(
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [brf_pkg::OP_W-1:0]  i_op,
    input  logic [brf_pkg::BYTE_W-1:0] i_data_in,
    input  logic [brf_pkg::LEN_W-1:0] i_length,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output brf_pkg::t_cmd             o_q_cmd
);
    import brf_pkg::*;

    localparam logic [LEN_W-1:0] BURST_MAX = LEN_W'(MAX_BURST);

    logic             w_known;
    logic [LEN_W-1:0] w_len_m1;

    assign w_len_m1   = i_length - LEN_W'(1);
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && w_known;

    // decode op into kind and a precomputed byte limit
    always_comb begin
        w_known      = 1'b1;
        o_q_cmd.kind = K_WRITE;
        o_q_cmd.pop  = 1'b1;
        o_q_cmd.data = i_data_in;
        o_q_cmd.lim  = '0;
        case (i_op)
            OP_WRITE: begin
                o_q_cmd.kind = K_WRITE;
            end
            OP_READ: begin
                o_q_cmd.kind = K_BURST;
                o_q_cmd.lim  = LEN_W'(1);
            end
            OP_READ_MANY, OP_PEEK: begin
                o_q_cmd.kind = K_BURST;
                o_q_cmd.pop  = (i_op == OP_READ_MANY);
                o_q_cmd.lim  = (i_length < BURST_MAX) ? i_length : BURST_MAX;
            end
            OP_READ_LINE: begin
                o_q_cmd.kind = K_LINE;
                if (i_length > LEN_W'(1)) begin
                    o_q_cmd.lim = (w_len_m1 < BURST_MAX) ? w_len_m1 : BURST_MAX;
                end
            end
            OP_FLUSH: begin
                o_q_cmd.kind = K_FLUSH;
            end
            default: begin
                w_known = 1'b0;   // unused codes: swallowed, no beats
            end
        endcase
    end

endmodule

// ===== sv/brf_queue.sv =====
module brf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brf_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_nonempty,
    input  logic          i_pop,
    output brf_pkg::t_cmd o_cmd
);
    import brf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_cmd      = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/brf_back.sv =====
module brf_back #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [brf_pkg::CAP_W-1:0]  i_cfg_capacity,
    input  logic                       i_cmd_valid,
    input  brf_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output brf_pkg::t_beat             o_out
);
    import brf_pkg::*;

    localparam int USED  = (DEPTH < 256) ? DEPTH : 256;
    localparam int PTR_W = $clog2(USED);
    localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(USED);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_BURST_RD,
        S_BURST_OUT,
        S_STAT
    } t_state;

    logic [BYTE_W-1:0] r_mem [USED];
    logic [BYTE_W-1:0] r_rd_data;

    t_state            r_state;
    logic [CAP_W-1:0]  r_cap;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CAP_W-1:0]  r_fill;
    logic [PTR_W-1:0]  r_ptr;
    logic [CAP_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_lim;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_pop;
    logic [ST_W-1:0]   r_pend;
    logic              r_out_valid;
    t_beat             r_out;

    logic              w_out_free;
    logic              w_take;
    logic              w_full;
    logic              w_mem_we;
    logic [PTR_W-1:0]  w_wp_adv;
    logic [PTR_W-1:0]  w_ptr_adv;
    logic [CAP_W-1:0]  w_burst_n;
    logic [CAP_W-1:0]  w_idx_p1;
    logic [CAP_W-1:0]  w_line_n;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                              input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] q;
        q = CAP_W'(p) + CAP_W'(1);
        return (q >= cap) ? '0 : q[PTR_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] clamp(input logic [CAP_W-1:0] v);
        if (v == '0) begin
            return CAP_W'(1);
        end
        return (v > CAP_LIM) ? CAP_LIM : v;
    endfunction

    function automatic t_beat stat_beat(input logic [ST_W-1:0] st);
        return '{byte_out: '0, has_byte: 1'b0, status: st, last: 1'b1};
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign w_full     = (r_fill >= r_cap);
    assign w_mem_we   = w_take && (i_cmd.kind == K_WRITE) && !w_full;
    assign w_wp_adv   = adv(r_wp, r_cap);
    assign w_ptr_adv  = adv(r_ptr, r_cap);
    assign w_burst_n  = (CAP_W'(i_cmd.lim) < r_fill) ? CAP_W'(i_cmd.lim) : r_fill;
    assign w_idx_p1   = r_idx + CAP_W'(1);
    assign w_line_n   = (w_idx_p1 < CAP_W'(r_lim)) ? w_idx_p1 : CAP_W'(r_lim);

    assign o_cmd_pop   = w_take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_LIM;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_out_valid <= 1'b1;
                        r_ptr       <= r_rp;
                        case (i_cmd.kind)
                            K_WRITE: begin
                                if (w_full) begin
                                    r_out <= stat_beat(ST_FULL);
                                end else begin
                                    r_out  <= stat_beat(ST_OK);
                                    r_wp   <= w_wp_adv;
                                    r_fill <= r_fill + CAP_W'(1);
                                end
                            end
                            K_BURST: begin
                                if (w_burst_n == '0) begin
                                    r_out <= stat_beat(ST_EMPTY);
                                end else begin
                                    r_out_valid <= !i_out_ready && r_out_valid;
                                    r_cnt       <= w_burst_n[LEN_W-1:0];
                                    r_pop       <= i_cmd.pop;
                                    r_state     <= S_BURST_RD;
                                end
                            end
                            K_LINE: begin
                                r_out_valid <= !i_out_ready && r_out_valid;
                                r_idx       <= '0;
                                r_lim       <= i_cmd.lim;
                                r_state     <= S_SCAN_RD;
                            end
                            K_FLUSH: begin
                                r_out  <= stat_beat(ST_OK);
                                r_wp   <= '0;
                                r_rp   <= '0;
                                r_fill <= '0;
                            end
                            default: begin
                                r_out <= stat_beat(ST_OK);
                            end
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx == r_fill) begin
                        r_pend  <= ST_NOLINE;
                        r_state <= S_STAT;
                    end else begin
                        r_state <= S_SCAN_CMP;
                    end
                end
                S_SCAN_CMP: begin
                    if (r_rd_data == NEWLINE) begin
                        r_ptr <= r_rp;
                        if (w_line_n == '0) begin
                            r_pend  <= ST_EMPTY;
                            r_state <= S_STAT;
                        end else begin
                            r_cnt   <= w_line_n[LEN_W-1:0];
                            r_pop   <= 1'b1;
                            r_state <= S_BURST_RD;
                        end
                    end else begin
                        r_ptr   <= w_ptr_adv;
                        r_idx   <= w_idx_p1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_BURST_RD: begin
                    r_state <= S_BURST_OUT;
                end
                S_BURST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{byte_out: r_rd_data, has_byte: 1'b1,
                                         status: ST_OK, last: (r_cnt == LEN_W'(1))};
                        r_ptr       <= w_ptr_adv;
                        r_cnt       <= r_cnt - LEN_W'(1);
                        if (r_pop) begin
                            r_rp   <= w_ptr_adv;
                            r_fill <= r_fill - CAP_W'(1);
                        end
                        r_state <= (r_cnt == LEN_W'(1)) ? S_IDLE : S_BURST_RD;
                    end
                end
                S_STAT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= stat_beat(r_pend);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // capacity write resets ring; user sends it when idle; unchecked
            if (i_cfg_valid) begin
                r_cap  <= clamp(i_cfg_capacity);
                r_wp   <= '0;
                r_rp   <= '0;
                r_fill <= '0;
            end
        end
    end

endmodule

// ===== sv/byte_ring_fifo_with_line_extract.sv =====
// Byte ring FIFO with burst read, peek and newline-delimited line extract.
//
// Channels
//   in  : i_in_valid / o_in_ready, one op per beat (i_op, i_data_in, i_length).
//   out : o_out_valid / i_out_ready, data beats (o_has_byte = 1) or a single
//         status beat; o_last marks the final beat of every answered op.
//   cfg : i_cfg_valid / o_cfg_ready, i_cfg_capacity. Always ready; a write sets
//         the ring size (0 acts as 1, clamps to the store depth) and empties it.
//
// Timing
//   Ops land in a two-entry command queue; the back end pulls one when its
//   output register is free. Write, flush and empty-burst status cases finish
//   in the idle state alone, so pushes sustain one beat per cycle while the
//   receiver does not stall. Each byte of a read, read-many, peek or line
//   burst passes S_BURST_RD then S_BURST_OUT (registered read of the byte
//   store); a line scan adds S_SCAN_RD and S_SCAN_CMP per byte up to the newline.
//
// Reset clears pointers, fill count and capacity (to full depth); stored
// bytes are not cleared. When the receiver stalls, the output register
// holds its beat, the back end waits, the queue fills and o_in_ready drops.
module byte_ring_fifo_with_line_extract #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [brf_pkg::CAP_W-1:0]   i_cfg_capacity,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [brf_pkg::OP_W-1:0]    i_op,
    input  logic [brf_pkg::BYTE_W-1:0]  i_data_in,
    input  logic [brf_pkg::LEN_W-1:0]   i_length,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [brf_pkg::BYTE_W-1:0]  o_byte_out,
    output logic                        o_has_byte,
    output logic [brf_pkg::ST_W-1:0]    o_status,
    output logic                        o_last
);
    import brf_pkg::*;

    logic  w_q_push;
    logic  w_q_full;
    logic  w_q_nonempty;
    logic  w_q_pop;
    t_cmd  w_front_cmd;
    t_cmd  w_back_cmd;
    t_beat w_beat;

    assign o_cfg_ready = 1'b1;

    // decode and limit computation
    brf_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_data_in  (i_data_in),
        .i_length   (i_length),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_front_cmd)
    );

    // decouples intake from execution
    brf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_cmd      (w_front_cmd),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .i_pop      (w_q_pop),
        .o_cmd      (w_back_cmd)
    );

    // ring store, pointers, scan and burst sequencer, output register
    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_cmd_valid    (w_q_nonempty),
        .i_cmd          (w_back_cmd),
        .o_cmd_pop      (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (w_beat)
    );

    assign o_byte_out = w_beat.byte_out;
    assign o_has_byte = w_beat.has_byte;
    assign o_status   = w_beat.status;
    assign o_last     = w_beat.last;

endmodule

// ===== sv/brf_chk.sv =====
module brf_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [brf_pkg::BYTE_W-1:0] o_byte_out,
    input logic                       o_has_byte,
    input logic [brf_pkg::ST_W-1:0]   o_status,
    input logic                       o_last
);
    import brf_pkg::*;

    // a status beat is always the whole answer of its op
    a_stat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |-> o_last)
        else $error("status beat without last");

    // data beats carry no error status
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_byte |-> o_status == ST_OK)
        else $error("data beat with nonzero status");

    // status beats carry a zero byte
    a_stat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |-> o_byte_out == '0)
        else $error("status beat with nonzero byte");

    // output register empty after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_out)
        && $stable(o_status) && $stable(o_last))
        else $error("stalled output beat changed");

endmodule

bind byte_ring_fifo_with_line_extract brf_chk u_brf_chk (.*);

// ===== dv/brf_ring_checker.sv =====
module brf_ring_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [brf_pkg::CAP_W-1:0]  i_cfg_capacity,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [brf_pkg::OP_W-1:0]   i_op,
    input  logic [brf_pkg::BYTE_W-1:0] i_data_in,
    input  logic [brf_pkg::LEN_W-1:0]  i_length,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [brf_pkg::BYTE_W-1:0] i_byte_out,
    input  logic                       i_has_byte,
    input  logic [brf_pkg::ST_W-1:0]   i_status,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    // shadow ring
    logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
    int unsigned       ring_wr;
    int unsigned       ring_rd;
    int unsigned       ring_fill;
    int unsigned       ring_cap;

    t_beat due_beats [$];
    t_beat want;
    int    fails = 0;

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_cap) ? 0 : p + 1;
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                        logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            fails++;
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        end
    endfunction

    task automatic queue_status(logic [ST_W-1:0] st);
        t_beat b;
        b.byte_out = '0;
        b.has_byte = 1'b0;
        b.status   = st;
        b.last     = 1'b1;
        due_beats.push_back(b);
    endtask

    // n bytes from the oldest; pop drops them from the ring
    task automatic queue_bytes(int unsigned n, bit pop);
        t_beat       b;
        int unsigned p;
        p = ring_rd;
        for (int unsigned i = 0; i < n; i++) begin
            b.byte_out = ring_mem[p];
            b.has_byte = 1'b1;
            b.status   = ST_OK;
            b.last     = (i + 1 == n);
            due_beats.push_back(b);
            p = ring_next(p);
        end
        if (pop) begin
            ring_rd   = p;
            ring_fill = ring_fill - n;
        end
    endtask

    task automatic predict_ring_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
                                   logic [LEN_W-1:0] len);
        int unsigned n;
        int unsigned i;
        int unsigned p;
        int unsigned cut;
        bit          found;
        case (op)
            OP_WRITE: begin
                if (ring_fill >= ring_cap) begin
                    queue_status(ST_FULL);
                end else begin
                    ring_mem[ring_wr] = din;
                    ring_wr = ring_next(ring_wr);
                    ring_fill++;
                    queue_status(ST_OK);
                end
            end
            OP_READ: begin
                if (ring_fill == 0) queue_status(ST_EMPTY);
                else queue_bytes(1, 1'b1);
            end
            OP_READ_MANY, OP_PEEK: begin
                n = 32'(len);
                if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
                if (n > ring_fill) n = ring_fill;
                if (n == 0) queue_status(ST_EMPTY);
                else queue_bytes(n, op == OP_READ_MANY);
            end
            OP_READ_LINE: begin
                found = 1'b0;
                p = ring_rd;
                i = 0;
                while (i < ring_fill && !found) begin
                    if (ring_mem[p] == NEWLINE) begin
                        found = 1'b1;
                    end else begin
                        p = ring_next(p);
                        i++;
                    end
                end
                if (!found) begin
                    queue_status(ST_NOLINE);
                end else begin
                    n   = i + 1;
                    cut = (len == 0) ? 0 : 32'(len) - 1;
                    if (cut < n) n = cut;
                    if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
                    if (n == 0) queue_status(ST_EMPTY);
                    else queue_bytes(n, 1'b1);
                end
            end
            OP_FLUSH: begin
                ring_wr   = 0;
                ring_rd   = 0;
                ring_fill = 0;
                queue_status(ST_OK);
            end
            default: begin
                // unused codes: no beats
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_wr   = 0;
            ring_rd   = 0;
            ring_fill = 0;
            ring_cap  = DEPTH_DEF;
            due_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_capacity == 0) ring_cap = 1;
                else if (i_cfg_capacity > DEPTH_DEF) ring_cap = DEPTH_DEF;
                else ring_cap = 32'(i_cfg_capacity);
                ring_wr   = 0;
                ring_rd   = 0;
                ring_fill = 0;
            end
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    fails++;
                    $error("unexpected beat: byte_out %0d has_byte %0d status %0d last %0d",
                           i_byte_out, i_has_byte, i_status, i_last);
                end else begin
                    want = due_beats.pop_front();
                    check_field("byte_out", want.byte_out, i_byte_out);
                    check_field("has_byte", BYTE_W'(want.has_byte), BYTE_W'(i_has_byte));
                    check_field("status", BYTE_W'(want.status), BYTE_W'(i_status));
                    check_field("last", BYTE_W'(want.last), BYTE_W'(i_last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_ring_op(i_op, i_data_in, i_length);
            end
        end
        o_pending    <= due_beats.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/byte_ring_fifo_with_line_extract_test.sv =====
module byte_ring_fifo_with_line_extract_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    localparam int HOLD_CYCLES = 400;       // long receiver hold-off
    localparam int TAIL_CYCLES = 24;        // quiet time before cfg writes and the verdict
    localparam int RUN_LIMIT   = 1_000_000;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic [CAP_W-1:0]  i_cfg_capacity = '0;
    logic              i_in_valid     = 1'b0;
    logic [OP_W-1:0]   i_op           = '0;
    logic [BYTE_W-1:0] i_data_in      = '0;
    logic [LEN_W-1:0]  i_length       = '0;
    logic              i_out_ready    = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_byte_out;
    logic              o_has_byte;
    logic [ST_W-1:0]   o_status;
    logic              o_last;

    int fail_count;
    int beats_due;

    // idle knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int cycle_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    byte_ring_fifo_with_line_extract i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_data_in      (i_data_in),
        .i_length       (i_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_out     (o_byte_out),
        .o_has_byte     (o_has_byte),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    brf_ring_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_data_in      (i_data_in),
        .i_length       (i_length),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_byte_out     (o_byte_out),
        .i_has_byte     (o_has_byte),
        .i_status       (o_status),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (beats_due)
    );

    // Watchdog: a stuck handshake or a missing beat ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request. The hold is
    // counted here so the sender keeps pushing and the block backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one op and return at the edge that accepts the beat. Valid stays
    // high into the next call unless that call opens a gap, so valid is never
    // dropped and raised in the same step.
    task automatic offer_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
                            logic [LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_data_in  <= din;
        i_length   <= len;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending, wait for every predicted beat, then let the block go
    // quiet (unused ops leave nothing to wait on).
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (beats_due != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Capacity write; only ever issued with the block idle.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        settle();
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic, biased toward text with newlines so line extraction,
    // partial lines, full and wrap all get exercised. Ignored ops are sent
    // but not counted.
    task automatic run_random(int count);
        int                done;
        int                pick;
        int                lsel;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] din;
        logic [LEN_W-1:0]  len;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 52) op = OP_WRITE;
            else if (pick < 67) op = OP_READ_LINE;
            else if (pick < 75) op = OP_READ;
            else if (pick < 83) op = OP_READ_MANY;
            else if (pick < 91) op = OP_PEEK;
            else if (pick < 94) op = OP_FLUSH;
            else if (pick < 97) op = OP_UNUSED_A;
            else op = OP_UNUSED_B;
            if ($urandom_range(4) == 0) din = NEWLINE;
            else din = BYTE_W'($urandom_range(255));
            lsel = $urandom_range(9);
            if (lsel < 7) len = LEN_W'($urandom_range(12));
            else if (lsel < 9) len = LEN_W'($urandom_range(64));
            else len = LEN_W'($urandom_range(127));
            offer_op(op, din, len);
            if (op != OP_UNUSED_A && op != OP_UNUSED_B) done++;
        end
    endtask

    initial begin
        logic [CAP_W-1:0]  cap;
        logic [BYTE_W-1:0] din;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, capacity at reset value ---
        // every read kind on an empty ring
        offer_op(OP_READ, 8'h00, 7'd0);
        offer_op(OP_READ_MANY, 8'h00, 7'd5);
        offer_op(OP_PEEK, 8'h00, 7'd64);
        offer_op(OP_READ_LINE, 8'h00, 7'd10);
        // partial line, no newline yet
        offer_op(OP_WRITE, 8'h00, 7'd0);
        offer_op(OP_WRITE, 8'hFF, 7'd0);
        offer_op(OP_WRITE, 8'h68, 7'd0);
        offer_op(OP_READ_LINE, 8'h00, 7'd10);
        offer_op(OP_WRITE, NEWLINE, 7'd0);
        // peek over-asks: trimmed to what is stored
        offer_op(OP_PEEK, 8'h00, 7'd127);
        // zero length burst, line buffers of 0 and 1
        offer_op(OP_READ_MANY, 8'h00, 7'd0);
        offer_op(OP_READ_LINE, 8'h00, 7'd0);
        offer_op(OP_READ_LINE, 8'h00, 7'd1);
        // line cut short by the buffer, then the remainder
        offer_op(OP_READ_LINE, 8'h00, 7'd3);
        offer_op(OP_READ_LINE, 8'h00, 7'd64);
        // ignored codes
        offer_op(OP_UNUSED_A, 8'h55, 7'h2A);
        offer_op(OP_UNUSED_B, 8'hAA, 7'h55);
        offer_op(OP_WRITE, 8'h5A, 7'd0);
        offer_op(OP_READ, 8'h00, 7'd0);
        offer_op(OP_WRITE, 8'h11, 7'd0);
        offer_op(OP_FLUSH, 8'h00, 7'd0);
        offer_op(OP_READ, 8'h00, 7'd0);

        // one-entry ring: full on the second write
        set_capacity(9'd1);
        offer_op(OP_WRITE, NEWLINE, 7'd0);
        offer_op(OP_WRITE, 8'h33, 7'd0);
        offer_op(OP_READ_LINE, 8'h00, 7'd2);

        // --- random phases: capacity and idle pattern change per phase ---
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    cap = 9'd0;      // acts as 1
                end
                1: begin
                    cap = 9'd3;
                end
                2: begin
                    cap = CAP_W'($urandom_range(24, 4));
                end
                3: begin
                    cap = 9'd511;    // saturates to depth
                end
                default: begin
                    cap = 9'd256;
                end
            endcase
            set_capacity(cap);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default: begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            run_random(6);
        end

        // --- back-pressure: receiver holds off while a long line goes in ---
        set_capacity(9'd100);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        for (int k = 0; k < 66; k++) begin
            din = BYTE_W'($urandom_range(255));
            if (din == NEWLINE) din = 8'h20;
            if (k == 65) din = NEWLINE;
            offer_op(OP_WRITE, din, 7'd0);
        end
        // line longer than a burst: cut at the burst limit
        offer_op(OP_READ_LINE, 8'h00, 7'd127);
        offer_op(OP_READ_MANY, 8'h00, 7'd127);

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
